// ----- rtl/core/bctm_pkg.sv -----
// ----------------------------------------------------------------------------
// bctm_pkg
// shared types and codes of the buffer cache tag manager
// ----------------------------------------------------------------------------
package bctm_pkg;

   localparam int KIND_W     = 2;
   localparam int BLOCK_IN_W = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 5;
   localparam int WB_OUT_W   = 13;
   // widest slot index and block number that the parameters allow
   localparam int IDX_MAX_W  = 8;
   localparam int BLK_MAX_W  = 16;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRTY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BOUND  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // flags of the scan packet that travels down the chain of cells
   typedef struct packed {
      logic active;
      logic alloc;
      logic free_found;
      logic vic_found;
      logic vic_dirty;
      logic hit;
   } scan_flags_type;

   // update broadcast to the cells once the scan is over
   typedef struct packed {
      logic install;
      logic set_dirty;
   } upd_cmd_type;

endpackage

// ----- rtl/core/bctm_cell.sv -----
// ----------------------------------------------------------------------------
// bctm_cell
// one buffer slot: holds its tag and works on the scan packet passing through
// ----------------------------------------------------------------------------
module bctm_cell #(
   parameter int IDX_W = 5,
   parameter int AGE_W = 16,
   parameter int BLK_W = 13,
   parameter int IDX   = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [BLK_W-1:0]           req_blk,
   input  bctm_pkg::scan_flags_type   flags_prev,
   input  logic [IDX_W-1:0]           free_idx_prev,
   input  logic [IDX_W-1:0]           vic_idx_prev,
   input  logic [AGE_W-1:0]           vic_age_prev,
   input  logic [BLK_W-1:0]           vic_block_prev,
   input  logic [IDX_W-1:0]           hit_idx_prev,
   input  bctm_pkg::upd_cmd_type      cmd,
   input  logic [IDX_W-1:0]           cmd_idx,
   output bctm_pkg::scan_flags_type   flags_next,
   output logic [IDX_W-1:0]           free_idx_next,
   output logic [IDX_W-1:0]           vic_idx_next,
   output logic [AGE_W-1:0]           vic_age_next,
   output logic [BLK_W-1:0]           vic_block_next,
   output logic [IDX_W-1:0]           hit_idx_next
);

   logic                     occ_ff, occ_in;
   logic                     dirty_ff, dirty_in;
   logic [BLK_W-1:0]         blk_ff, blk_in;
   logic [AGE_W-1:0]         age_ff, age_in;
   logic [AGE_W-1:0]         aged;
   logic                     sel;

   bctm_pkg::scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         vic_idx_ff, vic_idx_in;
   logic [AGE_W-1:0]         vic_age_ff, vic_age_in;
   logic [BLK_W-1:0]         vic_block_ff, vic_block_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;

   assign aged = (age_ff == {AGE_W{1'b1}}) ? age_ff : age_ff + AGE_W'(1);
   assign sel  = (cmd_idx == IDX_W'(IDX));

   // packet handling
   always_comb begin
      flags_in     = flags_prev;
      free_idx_in  = free_idx_prev;
      vic_idx_in   = vic_idx_prev;
      vic_age_in   = vic_age_prev;
      vic_block_in = vic_block_prev;
      hit_idx_in   = hit_idx_prev;
      if (flags_prev.active) begin
         if (!occ_ff) begin
            if (flags_prev.alloc && !flags_prev.free_found) begin
               flags_in.free_found = 1'b1;
               free_idx_in         = IDX_W'(IDX);
            end
         end else if (flags_prev.alloc) begin
            // strict compare keeps the lowest index on equal ages
            if (!flags_prev.vic_found || aged > vic_age_prev) begin
               flags_in.vic_found = 1'b1;
               flags_in.vic_dirty = dirty_ff;
               vic_idx_in         = IDX_W'(IDX);
               vic_age_in         = aged;
               vic_block_in       = blk_ff;
            end
         end else if (!flags_prev.hit && blk_ff == req_blk) begin
            flags_in.hit = 1'b1;
            hit_idx_in   = IDX_W'(IDX);
         end
      end
   end

   // own tag
   always_comb begin
      occ_in   = occ_ff;
      dirty_in = dirty_ff;
      blk_in   = blk_ff;
      age_in   = age_ff;
      if (flags_prev.active && flags_prev.alloc && occ_ff) begin
         age_in = aged;
      end
      if (cmd.install && sel) begin
         occ_in   = 1'b1;
         dirty_in = 1'b0;
         blk_in   = req_blk;
         age_in   = '0;
      end else if (cmd.set_dirty && sel) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= 1'b0;
         dirty_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         dirty_ff <= dirty_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      age_ff       <= age_in;
      free_idx_ff  <= free_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_age_ff   <= vic_age_in;
      vic_block_ff <= vic_block_in;
      hit_idx_ff   <= hit_idx_in;
   end

   assign flags_next     = flags_ff;
   assign free_idx_next  = free_idx_ff;
   assign vic_idx_next   = vic_idx_ff;
   assign vic_age_next   = vic_age_ff;
   assign vic_block_next = vic_block_ff;
   assign hit_idx_next   = hit_idx_ff;

endmodule

// ----- rtl/core/buffer_cache_tag_manager.sv -----
// ----------------------------------------------------------------------------
// buffer_cache_tag_manager
// tag store for buffer slots with age based replacement
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (kind, block number) under valid/ready;
// each gives exactly one word on the rsp_ channel (status, slot, write-back).
// Kinds: allocate a slot for a block, look a block up, mark its slot dirty.
// A request walks a row of NUM_SLOTS slot cells, one cell per cycle; each
// cell ages itself, offers itself as free slot or victim, or reports a hit.
// The slot update is broadcast once the walk ends.
// A request passes the launch register, each cell of the row, the capture
// into the result registers and the finish state before its word is
// registered; an out-of-bound block number skips the walk and goes from
// accept straight to the finish state. The next request is taken once the
// block is back in idle after the finish state of the previous one.
// One request is worked on at a time; req_ready is high only while idle.
// A finished word waits in the response register; a new request is taken
// while it waits, and the block holds its next word back until it is taken.
// Reset: synchronous, active high; all slots free and clean, no word pending.
// ----------------------------------------------------------------------------
module buffer_cache_tag_manager #(
   parameter int NUM_SLOTS  = 32,
   parameter int NUM_BLOCKS = 8192,
   parameter int AGE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bctm_pkg::KIND_W-1:0]         req_kind,
   input  logic [bctm_pkg::BLOCK_IN_W-1:0]     req_block_num,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bctm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bctm_pkg::SLOT_OUT_W-1:0]     rsp_slot_index,
   output logic                                rsp_writeback_valid,
   output logic [bctm_pkg::WB_OUT_W-1:0]       rsp_writeback_block
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int BLK_W = $clog2(NUM_BLOCKS);
   localparam int AGE_W = AGE_BITS;

   bctm_pkg::state_type      state_ff, state_in;

   logic [bctm_pkg::KIND_W-1:0] kind_ff;
   logic [BLK_W-1:0]         blk_ff;
   logic                     bound_ff;
   logic                     accept, bound, launch, capture, fire, rsp_free;

   bctm_pkg::scan_flags_type launch_ff, launch_in;
   bctm_pkg::upd_cmd_type    cmd;
   logic [IDX_W-1:0]         cmd_idx;

   // links between cells; link 0 is the launch register
   bctm_pkg::scan_flags_type flags_l     [NUM_SLOTS+1];
   logic [IDX_W-1:0]         free_idx_l  [NUM_SLOTS+1];
   logic [IDX_W-1:0]         vic_idx_l   [NUM_SLOTS+1];
   logic [AGE_W-1:0]         vic_age_l   [NUM_SLOTS+1];
   logic [BLK_W-1:0]         vic_block_l [NUM_SLOTS+1];
   logic [IDX_W-1:0]         hit_idx_l   [NUM_SLOTS+1];

   bctm_pkg::scan_flags_type res_flags_ff;
   logic [IDX_W-1:0]         res_free_idx_ff, res_vic_idx_ff, res_hit_idx_ff;
   logic [BLK_W-1:0]         res_vic_block_ff;
   logic [IDX_W-1:0]         target;

   logic                     rsp_valid_ff;
   logic [bctm_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bctm_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                     rsp_wb_valid_ff, rsp_wb_valid_in;
   logic [bctm_pkg::WB_OUT_W-1:0]   rsp_wb_block_ff, rsp_wb_block_in;
   logic [bctm_pkg::IDX_MAX_W-1:0]  slot_wide;
   logic [bctm_pkg::BLK_MAX_W-1:0]  blk_wide;

   assign accept   = req_valid && req_ready;
   assign bound    = ({1'b0, req_block_num} >= 17'(NUM_BLOCKS));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bctm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bound ? bctm_pkg::ST_FINISH : bctm_pkg::ST_SCAN;
            end
         end
         bctm_pkg::ST_SCAN: begin
            if (flags_l[NUM_SLOTS].active) begin
               state_in = bctm_pkg::ST_FINISH;
            end
         end
         bctm_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = bctm_pkg::ST_IDLE;
            end
         end
         default: state_in = bctm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      launch    = 1'b0;
      capture   = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         bctm_pkg::ST_IDLE:   begin
            req_ready = 1'b1;
            launch    = req_valid && !bound;
         end
         bctm_pkg::ST_SCAN:   capture = flags_l[NUM_SLOTS].active;
         bctm_pkg::ST_FINISH: fire    = rsp_free;
         default:             req_ready = 1'b0;
      endcase
   end

   always_comb begin
      launch_in        = '0;
      launch_in.active = launch;
      launch_in.alloc  = (req_kind == bctm_pkg::KIND_ALLOC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bctm_pkg::ST_IDLE;
         launch_ff <= '0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         blk_ff   <= req_block_num[BLK_W-1:0];
         bound_ff <= bound;
      end
      if (capture) begin
         res_flags_ff     <= flags_l[NUM_SLOTS];
         res_free_idx_ff  <= free_idx_l[NUM_SLOTS];
         res_vic_idx_ff   <= vic_idx_l[NUM_SLOTS];
         res_vic_block_ff <= vic_block_l[NUM_SLOTS];
         res_hit_idx_ff   <= hit_idx_l[NUM_SLOTS];
      end
   end

   assign flags_l[0]     = launch_ff;
   assign free_idx_l[0]  = '0;
   assign vic_idx_l[0]   = '0;
   assign vic_age_l[0]   = '0;
   assign vic_block_l[0] = '0;
   assign hit_idx_l[0]   = '0;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      bctm_cell #(
         .IDX_W (IDX_W),
         .AGE_W (AGE_W),
         .BLK_W (BLK_W),
         .IDX   (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .req_blk        (blk_ff),
         .flags_prev     (flags_l[i]),
         .free_idx_prev  (free_idx_l[i]),
         .vic_idx_prev   (vic_idx_l[i]),
         .vic_age_prev   (vic_age_l[i]),
         .vic_block_prev (vic_block_l[i]),
         .hit_idx_prev   (hit_idx_l[i]),
         .cmd            (cmd),
         .cmd_idx        (cmd_idx),
         .flags_next     (flags_l[i+1]),
         .free_idx_next  (free_idx_l[i+1]),
         .vic_idx_next   (vic_idx_l[i+1]),
         .vic_age_next   (vic_age_l[i+1]),
         .vic_block_next (vic_block_l[i+1]),
         .hit_idx_next   (hit_idx_l[i+1])
      );
   end

   // lowest free slot first, else the oldest one
   assign target = res_flags_ff.free_found ? res_free_idx_ff
                 : (res_flags_ff.vic_found ? res_vic_idx_ff : '0);

   always_comb begin
      cmd       = '0;
      cmd_idx   = target;
      if (fire && !bound_ff) begin
         if (kind_ff == bctm_pkg::KIND_ALLOC) begin
            cmd.install = 1'b1;
         end else if (kind_ff == bctm_pkg::KIND_DIRTY && res_flags_ff.hit) begin
            cmd.set_dirty = 1'b1;
            cmd_idx       = res_hit_idx_ff;
         end
      end
   end

   // response word
   always_comb begin
      rsp_status_in   = bctm_pkg::STATUS_OK;
      slot_wide       = '0;
      rsp_wb_valid_in = 1'b0;
      blk_wide        = '0;
      if (bound_ff) begin
         rsp_status_in = bctm_pkg::STATUS_BOUND;
      end else if (kind_ff == bctm_pkg::KIND_ALLOC) begin
         slot_wide = bctm_pkg::IDX_MAX_W'(target);
         if (!res_flags_ff.free_found && res_flags_ff.vic_dirty) begin
            rsp_wb_valid_in = 1'b1;
            blk_wide        = bctm_pkg::BLK_MAX_W'(res_vic_block_ff);
         end
      end else if (res_flags_ff.hit) begin
         slot_wide = bctm_pkg::IDX_MAX_W'(res_hit_idx_ff);
      end else begin
         rsp_status_in = bctm_pkg::STATUS_ABSENT;
      end
      rsp_slot_in     = slot_wide[bctm_pkg::SLOT_OUT_W-1:0];
      rsp_wb_block_in = blk_wide[bctm_pkg::WB_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_slot_ff     <= rsp_slot_in;
         rsp_wb_valid_ff <= rsp_wb_valid_in;
         rsp_wb_block_ff <= rsp_wb_block_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_writeback_valid = rsp_wb_valid_ff;
   assign rsp_writeback_block = rsp_wb_block_ff;

   // scan packet only ever reaches the end of the row during a walk
   a_packet_in_scan : assert property (@(posedge clock) disable iff (reset)
      flags_l[NUM_SLOTS].active |-> state_ff == bctm_pkg::ST_SCAN)
      else $error("scan packet left the row outside a walk");

   a_single_cmd : assert property (@(posedge clock) disable iff (reset)
      !(cmd.install && cmd.set_dirty))
      else $error("install and set dirty issued together");

   a_fire_gives_word : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("finished request did not raise a response word");

   a_bound_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bctm_pkg::STATUS_BOUND) |->
         (!rsp_writeback_valid && rsp_slot_index == '0))
      else $error("out of bound word carries a slot or write-back");

endmodule

// ----- sim/bctm_checker.sv -----
// ----------------------------------------------------------------------------
// bctm_checker
// watches the request and reply channels of the tag manager and checks
// every reply word against a slot table kept alongside the block
// ----------------------------------------------------------------------------
module bctm_checker #(
   parameter int NUM_SLOTS  = 32,
   parameter int NUM_BLOCKS = 8192,
   parameter int AGE_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [bctm_pkg::KIND_W-1:0]     req_kind,
   input  logic [bctm_pkg::BLOCK_IN_W-1:0] req_block_num,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [bctm_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [bctm_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   input  logic                            rsp_writeback_valid,
   input  logic [bctm_pkg::WB_OUT_W-1:0]   rsp_writeback_block,
   output int                              mismatches,
   output int                              pending,
   output int                              words_checked,
   output int                              writebacks
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bctm_pkg::STATUS_W-1:0]   status;
      logic [bctm_pkg::SLOT_OUT_W-1:0] slot;
      logic                            wb_valid;
      logic [bctm_pkg::WB_OUT_W-1:0]   wb_block;
   } tag_reply_type;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   logic                          slot_used  [NUM_SLOTS];
   logic                          slot_dirty [NUM_SLOTS];
   logic [bctm_pkg::WB_OUT_W-1:0] slot_tag   [NUM_SLOTS];
   logic [AGE_BITS-1:0]           slot_age   [NUM_SLOTS];

   tag_reply_type expected_replies[$];
   tag_reply_type want;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // updates the slot table for one request and returns the word it causes
   function automatic tag_reply_type predict_tag_reply(
         input logic [bctm_pkg::KIND_W-1:0]     kind,
         input logic [bctm_pkg::BLOCK_IN_W-1:0] blk);
      tag_reply_type       r;
      int                  free_slot;
      int                  victim;
      int                  hit;
      logic [AGE_BITS-1:0] oldest;
      r         = '0;
      free_slot = -1;
      victim    = -1;
      hit       = -1;
      oldest    = '0;
      if (blk >= NUM_BLOCKS) begin
         r.status = bctm_pkg::STATUS_BOUND;
      end else if (kind == bctm_pkg::KIND_ALLOC) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_used[i]) begin
               if (free_slot < 0) free_slot = i;
            end else begin
               if (slot_age[i] != AGE_MAX) slot_age[i]++;
               if (victim < 0 || slot_age[i] > oldest) begin
                  oldest = slot_age[i];
                  victim = i;
               end
            end
         end
         // table full: oldest slot goes, lowest index on ties
         if (free_slot < 0) begin
            free_slot = victim;
            if (slot_dirty[free_slot]) begin
               r.wb_valid = 1'b1;
               r.wb_block = slot_tag[free_slot];
            end
         end
         slot_used[free_slot]  = 1'b1;
         slot_dirty[free_slot] = 1'b0;
         slot_tag[free_slot]   = blk[bctm_pkg::WB_OUT_W-1:0];
         slot_age[free_slot]   = '0;
         r.slot = free_slot[bctm_pkg::SLOT_OUT_W-1:0];
      end else begin
         // lookup, mark dirty and the spare kind all search the table
         for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_tag[i] == blk[bctm_pkg::WB_OUT_W-1:0]) hit = i;
         end
         if (hit < 0) begin
            r.status = bctm_pkg::STATUS_ABSENT;
         end else begin
            r.slot = hit[bctm_pkg::SLOT_OUT_W-1:0];
            if (kind == bctm_pkg::KIND_DIRTY) slot_dirty[hit] = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_dirty[i] = 1'b0;
            slot_tag[i]   = '0;
            slot_age[i]   = '0;
         end
         expected_replies.delete();
         mismatches    = 0;
         pending       = 0;
         words_checked = 0;
         writebacks    = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(predict_tag_reply(req_kind, req_block_num));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("word with nothing expected: status %0d slot %0d",
                                         rsp_status, rsp_slot_index));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status != want.status)
                  report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                            words_checked, rsp_status, want.status));
               if (rsp_slot_index != want.slot)
                  report_mismatch($sformatf("word %0d slot %0d, expected %0d",
                                            words_checked, rsp_slot_index, want.slot));
               if (rsp_writeback_valid != want.wb_valid)
                  report_mismatch($sformatf("word %0d write-back flag %0d, expected %0d",
                                            words_checked, rsp_writeback_valid,
                                            want.wb_valid));
               if (rsp_writeback_block != want.wb_block)
                  report_mismatch($sformatf("word %0d write-back block %0d, expected %0d",
                                            words_checked, rsp_writeback_block,
                                            want.wb_block));
               words_checked++;
               if (want.wb_valid) writebacks++;
            end
         end
         pending = expected_replies.size();
      end
   end

endmodule

// ----- sim/tb_buffer_cache_tag_manager.sv -----
// ----------------------------------------------------------------------------
// tb_buffer_cache_tag_manager
// directed and random requests against the buffer cache tag manager
// ----------------------------------------------------------------------------
// A short directed run hits the bound edges, absent blocks, the spare kind,
// duplicate installs and dirty marking; random traffic over a drifting pool
// of block numbers then forces evictions and write-backs under four mixes
// of sender idling and receiver stalling. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_buffer_cache_tag_manager;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS  = 32;
   localparam int NUM_BLOCKS = 8192;
   localparam int AGE_BITS   = 16;
   localparam int POOL_SIZE  = 48;
   localparam int PHASE_LEN  = 470;
   localparam logic [bctm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam logic [bctm_pkg::BLOCK_IN_W-1:0] BLK_LAST =
      bctm_pkg::BLOCK_IN_W'(NUM_BLOCKS - 1);
   localparam logic [bctm_pkg::BLOCK_IN_W-1:0] BLK_OVER =
      bctm_pkg::BLOCK_IN_W'(NUM_BLOCKS);

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic [bctm_pkg::KIND_W-1:0]     req_kind      = bctm_pkg::KIND_ALLOC;
   logic [bctm_pkg::BLOCK_IN_W-1:0] req_block_num = '0;
   logic                            rsp_ready     = 1'b0;
   logic                            req_ready;
   logic                            rsp_valid;
   logic [bctm_pkg::STATUS_W-1:0]   rsp_status;
   logic [bctm_pkg::SLOT_OUT_W-1:0] rsp_slot_index;
   logic                            rsp_writeback_valid;
   logic [bctm_pkg::WB_OUT_W-1:0]   rsp_writeback_block;

   int mismatches;
   int pending;
   int words_checked;
   int writebacks;

   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;
   logic [bctm_pkg::BLOCK_IN_W-1:0] block_pool [POOL_SIZE];

   always #5 clock = ~clock;

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   buffer_cache_tag_manager #(
      .NUM_SLOTS (NUM_SLOTS),
      .NUM_BLOCKS(NUM_BLOCKS),
      .AGE_BITS  (AGE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_block_num      (req_block_num),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_writeback_valid(rsp_writeback_valid),
      .rsp_writeback_block(rsp_writeback_block)
   );

   bctm_checker #(
      .NUM_SLOTS (NUM_SLOTS),
      .NUM_BLOCKS(NUM_BLOCKS),
      .AGE_BITS  (AGE_BITS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_block_num      (req_block_num),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_writeback_valid(rsp_writeback_valid),
      .rsp_writeback_block(rsp_writeback_block),
      .mismatches         (mismatches),
      .pending            (pending),
      .words_checked      (words_checked),
      .writebacks         (writebacks)
   );

   // entered and left at a falling edge; valid only drops during an idle gap
   task automatic push_request(input logic [bctm_pkg::KIND_W-1:0] kind,
                               input logic [bctm_pkg::BLOCK_IN_W-1:0] blk);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_block_num <= blk;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   initial begin
      #(8_000_000);
      $display("timeout with %0d words still outstanding", pending);
      $display("buffer_cache_tag_manager verification failed");
      $finish;
   end

   initial begin
      int                              roll;
      logic [bctm_pkg::KIND_W-1:0]     kind;
      logic [bctm_pkg::BLOCK_IN_W-1:0] blk;
      for (int i = 0; i < POOL_SIZE; i++) begin
         block_pool[i] = bctm_pkg::BLOCK_IN_W'($urandom_range(0, NUM_BLOCKS - 1));
      end
      block_pool[0]             = '0;
      block_pool[POOL_SIZE - 1] = BLK_LAST;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, bound edges on every kind
      push_request(bctm_pkg::KIND_LOOKUP, 16'd0);
      push_request(bctm_pkg::KIND_DIRTY,  16'd0);
      push_request(bctm_pkg::KIND_ALLOC,  16'hFFFF);
      push_request(bctm_pkg::KIND_ALLOC,  BLK_OVER);
      push_request(bctm_pkg::KIND_LOOKUP, BLK_OVER);
      push_request(bctm_pkg::KIND_DIRTY,  16'hFFFF);
      push_request(KIND_SPARE,            16'hFFFF);
      // first installs at the range ends
      push_request(bctm_pkg::KIND_ALLOC,  16'd0);
      push_request(bctm_pkg::KIND_ALLOC,  BLK_LAST);
      push_request(bctm_pkg::KIND_LOOKUP, BLK_LAST);
      push_request(bctm_pkg::KIND_DIRTY,  BLK_LAST);
      push_request(KIND_SPARE,            BLK_LAST);
      push_request(bctm_pkg::KIND_LOOKUP, 16'd0);
      push_request(bctm_pkg::KIND_DIRTY,  16'd0);
      // same block twice: search must find the lower slot
      push_request(bctm_pkg::KIND_ALLOC,  BLK_LAST);
      push_request(bctm_pkg::KIND_LOOKUP, BLK_LAST);
      push_request(bctm_pkg::KIND_LOOKUP, 16'd4096);
      push_request(bctm_pkg::KIND_DIRTY,  16'd1);
      push_request(KIND_SPARE,            16'd1);
      push_request(bctm_pkg::KIND_ALLOC,  16'h1555);
      push_request(bctm_pkg::KIND_ALLOC,  16'h0AAA);
      push_request(bctm_pkg::KIND_DIRTY,  16'h1555);
      push_request(KIND_SPARE,            16'h0AAA);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         for (int n = 0; n < PHASE_LEN; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      kind = bctm_pkg::KIND_ALLOC;
            else if (roll < 72) kind = bctm_pkg::KIND_LOOKUP;
            else if (roll < 92) kind = bctm_pkg::KIND_DIRTY;
            else                kind = KIND_SPARE;
            // mostly a recurring set of blocks so that hits and evictions happen
            roll = $urandom_range(0, 99);
            if (roll < 80)
               blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (roll < 90)
               blk = bctm_pkg::BLOCK_IN_W'($urandom_range(0, NUM_BLOCKS - 1));
            else if (roll < 95)
               blk = bctm_pkg::BLOCK_IN_W'($urandom_range(NUM_BLOCKS - 2, NUM_BLOCKS + 1));
            else
               blk = bctm_pkg::BLOCK_IN_W'($urandom());
            if ($urandom_range(0, 49) == 0)
               block_pool[$urandom_range(0, POOL_SIZE - 1)] =
                  bctm_pkg::BLOCK_IN_W'($urandom_range(0, NUM_BLOCKS - 1));
            push_request(kind, blk);
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("covered %0d requests: directed edges, then four idle and stall mixes",
               sent);
      $display("%0d reply words checked, %0d of them with a write-back",
               words_checked, writebacks);
      if (mismatches == 0 && pending == 0) begin
         $display("buffer_cache_tag_manager verification clean");
      end else begin
         $display("buffer_cache_tag_manager verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bctm_pkg.sv
rtl/core/bctm_cell.sv
rtl/core/buffer_cache_tag_manager.sv
sim/bctm_checker.sv
sim/tb_buffer_cache_tag_manager.sv
